FILE: rtl/core/c8_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c8_pkg
// Shared types, opcode codes and the built-in hex font of the CHIP-8 core.
// ----------------------------------------------------------------------------
package c8_pkg;

  localparam int unsigned AddrW  = 12;
  localparam int unsigned RowW   = 5;
  localparam int unsigned ScreenW = 64;
  localparam int unsigned FontBytes = 80;

  localparam logic [AddrW-1:0] PC_START  = 12'h200;
  localparam logic [AddrW-1:0] FONT_BASE = 12'h050;

  typedef enum logic [2:0] {
    CMD_WRITE = 3'd0,
    CMD_EXEC  = 3'd1,
    CMD_TICK  = 3'd2,
    CMD_ROW   = 3'd3,
    CMD_READ  = 3'd4
  } cmd_e;

  typedef enum logic [3:0] {
    OPC_SYS  = 4'h0, OPC_JP   = 4'h1, OPC_CALL = 4'h2, OPC_SEI  = 4'h3,
    OPC_SNEI = 4'h4, OPC_SER  = 4'h5, OPC_LDI  = 4'h6, OPC_ADDI = 4'h7,
    OPC_ALU  = 4'h8, OPC_SNER = 4'h9, OPC_LDIX = 4'hA, OPC_JPV0 = 4'hB,
    OPC_RND  = 4'hC, OPC_DRW  = 4'hD, OPC_KEY  = 4'hE, OPC_MISC = 4'hF
  } opc_e;

  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [15:0] OP_RET = 16'h00EE;

  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  localparam logic [7:0] KEY_SKP  = 8'h9E;
  localparam logic [7:0] KEY_SKNP = 8'hA1;

  localparam logic [7:0] FN_GET_DT = 8'h07;
  localparam logic [7:0] FN_WAIT_K = 8'h0A;
  localparam logic [7:0] FN_SET_DT = 8'h15;
  localparam logic [7:0] FN_SET_ST = 8'h18;
  localparam logic [7:0] FN_ADD_I  = 8'h1E;
  localparam logic [7:0] FN_FONT   = 8'h29;
  localparam logic [7:0] FN_BCD    = 8'h33;
  localparam logic [7:0] FN_STORE  = 8'h55;
  localparam logic [7:0] FN_LOAD   = 8'h65;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_MEMRD, ST_ROWRD,
    ST_FETCH0, ST_FETCH1, ST_FETCH2, ST_FETCH3, ST_EXEC,
    ST_RET, ST_FLAG, ST_DRAW_RD, ST_DRAW_WR, ST_BCD,
    ST_STORE_RD, ST_STORE_WR, ST_LOAD_RD, ST_LOAD_WR, ST_DONE
  } state_e;

  localparam logic [7:0] FONT [FontBytes] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  function automatic logic [7:0] font_byte(input logic [AddrW-1:0] a);
    logic [AddrW-1:0] off;
    off = a - FONT_BASE;
    if (a >= FONT_BASE && a < FONT_BASE + AddrW'(FontBytes)) begin
      return FONT[off[6:0]];
    end
    return 8'h00;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/chip8_instruction_core_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chip8_instruction_core_top
// CHIP-8 core: program memory, registers, stack, timers and frame buffer.
// After reset a clearing pass writes every program memory address, loading the
// font and zeroing the rest; no transaction is taken before it ends.
// Each memory has a single read port, so reads are issued one by one and
// multi-byte instructions step through their states in order. One
// transaction is in work at a time; the next is taken the cycle after the
// result is loaded.
// ----------------------------------------------------------------------------
module chip8_instruction_core_top #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  command_i,
  input  wire logic [11:0] address_i,
  input  wire logic [7:0]  write_data_i,
  input  wire logic [15:0] keys_down_i,
  input  wire logic [7:0]  random_byte_i,
  input  wire logic [4:0]  row_select_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       read_data_o,
  output logic [63:0]      display_row_o,
  output logic [11:0]      program_counter_o,
  output logic             display_changed_o,
  output logic             sound_on_o,
  output logic             waiting_for_key_o,
  output logic             stack_fault_o
);
  import c8_pkg::*;

  localparam int unsigned SpW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SaW = $clog2(STACK_DEPTH);

  state_e        state_q, state_d;
  logic [11:0]   clr_q, clr_d;
  logic [11:0]   pc_q, pc_d, i_q, i_d;
  logic [SpW-1:0] sp_q, sp_d;
  logic [7:0]    dt_q, dt_d, st_q, st_d;
  logic [31:0]   fb_vld_q, fb_vld_d;
  logic [15:0]   v_vld_q, v_vld_d;
  logic [3:0]    cnt_q, cnt_d;
  logic          hit_q, hit_d, flag_q, flag_d;
  logic          out_valid_q, out_valid_d, out_load;
  logic          chg_q, chg_d, wait_q, wait_d, fault_q, fault_d;

  logic [15:0]   op_q, op_d;
  logic [7:0]    vx_q, vx_d, vy_q, vy_d;
  cmd_e          cmd_q, cmd_d;
  logic [11:0]   addr_q, addr_d;
  logic [7:0]    wd_q, wd_d, rnd_q, rnd_d, rd_q, rd_d;
  logic [15:0]   keys_q, keys_d;
  logic [4:0]    row_q, row_d;
  logic [63:0]   drow_q, drow_d;

  logic          pm_we;
  logic [11:0]   pm_waddr, pm_raddr;
  logic [7:0]    pm_wdata, pm_rdata;
  logic          v_we;
  logic [3:0]    v_waddr, v_raddr, v_raddr_q;
  logic [7:0]    v_wdata, v_rdata, v_rd;
  logic          stk_we;
  logic [SaW-1:0] stk_waddr, stk_raddr;
  logic [11:0]   stk_wdata, stk_rdata;
  logic          fb_we;
  logic [4:0]    fb_waddr, fb_raddr;
  logic [63:0]   fb_wdata, fb_rdata;

  logic [3:0]    op_x, op_y, op_n;
  logic [7:0]    op_nn;
  logic [11:0]   op_nnn;
  logic [8:0]    sum9;
  logic [3:0]    key_idx;
  logic          key_any;
  logic [1:0]    bcd_h;
  logic [7:0]    bcd_r;
  logic [14:0]   bcd_prod;
  logic [3:0]    bcd_t, bcd_o;
  logic [4:0]    draw_y;
  logic [63:0]   spr, spr_rot, fb_old;
  logic [127:0]  spr_dbl;

  c8_ram #(.Width(8), .Depth(4096)) u_pmem (
    .clk_i, .we_i(pm_we), .waddr_i(pm_waddr), .wdata_i(pm_wdata),
    .raddr_i(pm_raddr), .rdata_o(pm_rdata)
  );
  c8_ram #(.Width(8), .Depth(16)) u_vreg (
    .clk_i, .we_i(v_we), .waddr_i(v_waddr), .wdata_i(v_wdata),
    .raddr_i(v_raddr), .rdata_o(v_rdata)
  );
  c8_ram #(.Width(12), .Depth(STACK_DEPTH)) u_stack (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(stk_wdata),
    .raddr_i(stk_raddr), .rdata_o(stk_rdata)
  );
  c8_ram #(.Width(64), .Depth(32)) u_fb (
    .clk_i, .we_i(fb_we), .waddr_i(fb_waddr), .wdata_i(fb_wdata),
    .raddr_i(fb_raddr), .rdata_o(fb_rdata)
  );

  assign op_x   = op_q[11:8];
  assign op_y   = op_q[7:4];
  assign op_n   = op_q[3:0];
  assign op_nn  = op_q[7:0];
  assign op_nnn = op_q[11:0];
  assign sum9   = {1'b0, vx_q} + {1'b0, vy_q};
  assign v_rd   = v_vld_q[v_raddr_q] ? v_rdata : 8'h00;

  always_comb begin
    key_idx = 4'd0;
    key_any = |keys_q;
    for (int k = 15; k >= 0; k--) begin
      if (keys_q[k]) begin
        key_idx = 4'(k);
      end
    end
  end

  always_comb begin
    bcd_h    = (vx_q >= 8'd200) ? 2'd2 : (vx_q >= 8'd100) ? 2'd1 : 2'd0;
    bcd_r    = vx_q - ((bcd_h == 2'd2) ? 8'd200 : (bcd_h == 2'd1) ? 8'd100 : 8'd0);
    bcd_prod = {8'd0, bcd_r[6:0]} * 15'd205;
    bcd_t    = bcd_prod[14:11];
    bcd_o    = 4'(bcd_r - ({4'd0, bcd_t} * 8'd10));
  end

  always_comb begin
    draw_y = vy_q[4:0] + {1'b0, cnt_q};
    for (int c = 0; c < ScreenW; c++) begin
      spr[c] = (c < 8) ? pm_rdata[7 - (c % 8)] : 1'b0;
    end
    spr_dbl = {spr, spr} << vx_q[5:0];
    spr_rot = spr_dbl[127:64];
    fb_old  = fb_vld_q[draw_y] ? fb_rdata : 64'd0;
  end

  always_comb begin
    state_d = state_q;  clr_d = clr_q;  pc_d = pc_q;  i_d = i_q;
    sp_d = sp_q;  dt_d = dt_q;  st_d = st_q;  fb_vld_d = fb_vld_q;
    v_vld_d = v_vld_q;  cnt_d = cnt_q;  hit_d = hit_q;  flag_d = flag_q;
    chg_d = chg_q;  wait_d = wait_q;  fault_d = fault_q;
    op_d = op_q;  vx_d = vx_q;  vy_d = vy_q;  cmd_d = cmd_q;  addr_d = addr_q;
    wd_d = wd_q;  rnd_d = rnd_q;  rd_d = rd_q;  keys_d = keys_q;  row_d = row_q;
    drow_d = drow_q;
    pm_we = 1'b0;  pm_waddr = 12'd0;  pm_wdata = 8'd0;  pm_raddr = 12'd0;
    v_we = 1'b0;  v_waddr = 4'd0;  v_wdata = 8'd0;  v_raddr = 4'd0;
    stk_we = 1'b0;  stk_waddr = '0;  stk_wdata = 12'd0;  stk_raddr = '0;
    fb_we = 1'b0;  fb_waddr = 5'd0;  fb_wdata = 64'd0;  fb_raddr = 5'd0;
    out_load = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_CLEAR: begin
        pm_we    = 1'b1;
        pm_waddr = clr_q;
        pm_wdata = font_byte(clr_q);
        clr_d    = clr_q + 12'd1;
        if (&clr_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d = cmd_e'(command_i);  addr_d = address_i;  wd_d = write_data_i;
          keys_d = keys_down_i;  rnd_d = random_byte_i;  row_d = row_select_i;
          rd_d = 8'd0;  drow_d = 64'd0;
          chg_d = 1'b0;  wait_d = 1'b0;  fault_d = 1'b0;
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_d = ST_DONE;
        case (cmd_q)
          CMD_WRITE: begin
            pm_we = 1'b1;  pm_waddr = addr_q;  pm_wdata = wd_q;
          end
          CMD_EXEC: begin
            pm_raddr = pc_q;  state_d = ST_FETCH0;
          end
          CMD_TICK: begin
            if (dt_q != 8'd0) dt_d = dt_q - 8'd1;
            if (st_q != 8'd0) st_d = st_q - 8'd1;
          end
          CMD_ROW: begin
            fb_raddr = row_q;  state_d = ST_ROWRD;
          end
          CMD_READ: begin
            pm_raddr = addr_q;  state_d = ST_MEMRD;
          end
          default: ;
        endcase
      end
      ST_MEMRD: begin
        rd_d = pm_rdata;  state_d = ST_DONE;
      end
      ST_ROWRD: begin
        drow_d = fb_vld_q[row_q] ? fb_rdata : 64'd0;  state_d = ST_DONE;
      end
      ST_FETCH0: begin
        op_d[15:8] = pm_rdata;
        pm_raddr   = pc_q + 12'd1;
        state_d    = ST_FETCH1;
      end
      ST_FETCH1: begin
        op_d[7:0] = pm_rdata;
        v_raddr   = op_q[11:8];
        pc_d      = pc_q + 12'd2;
        state_d   = ST_FETCH2;
      end
      ST_FETCH2: begin
        vx_d    = v_rd;
        v_raddr = op_y;
        state_d = ST_FETCH3;
      end
      ST_FETCH3: begin
        vy_d    = v_rd;
        v_raddr = 4'd0;
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_DONE;
        cnt_d   = 4'd0;
        hit_d   = 1'b0;
        unique case (opc_e'(op_q[15:12]))
          OPC_SYS: begin
            if (op_q == OP_CLS) begin
              fb_vld_d = 32'd0;  chg_d = 1'b1;
            end else if (op_q == OP_RET) begin
              if (sp_q == '0) begin
                fault_d = 1'b1;
              end else begin
                sp_d      = sp_q - SpW'(1);
                stk_raddr = SaW'(sp_q - SpW'(1));
                state_d   = ST_RET;
              end
            end
          end
          OPC_JP: pc_d = op_nnn;
          OPC_CALL: begin
            if (sp_q >= SpW'(STACK_DEPTH)) begin
              fault_d = 1'b1;
            end else begin
              stk_we = 1'b1;  stk_waddr = SaW'(sp_q);  stk_wdata = pc_q;
              sp_d = sp_q + SpW'(1);  pc_d = op_nnn;
            end
          end
          OPC_SEI:  if (vx_q == op_nn) pc_d = pc_q + 12'd2;
          OPC_SNEI: if (vx_q != op_nn) pc_d = pc_q + 12'd2;
          OPC_SER:  if (vx_q == vy_q) pc_d = pc_q + 12'd2;
          OPC_SNER: if (vx_q != vy_q) pc_d = pc_q + 12'd2;
          OPC_LDI: begin
            v_we = 1'b1;  v_waddr = op_x;  v_wdata = op_nn;
          end
          OPC_ADDI: begin
            v_we = 1'b1;  v_waddr = op_x;  v_wdata = vx_q + op_nn;
          end
          OPC_ALU: begin
            v_waddr = op_x;
            v_we    = 1'b1;
            state_d = ST_FLAG;
            case (op_n)
              ALU_MOV: begin v_wdata = vy_q;         state_d = ST_DONE; end
              ALU_OR:  begin v_wdata = vx_q | vy_q;  state_d = ST_DONE; end
              ALU_AND: begin v_wdata = vx_q & vy_q;  state_d = ST_DONE; end
              ALU_XOR: begin v_wdata = vx_q ^ vy_q;  state_d = ST_DONE; end
              ALU_ADD: begin v_wdata = sum9[7:0];    flag_d = sum9[8]; end
              ALU_SUB: begin v_wdata = vx_q - vy_q;  flag_d = vx_q >= vy_q; end
              ALU_SHR: begin v_wdata = vx_q >> 1;    flag_d = vx_q[0]; end
              ALU_SBN: begin v_wdata = vy_q - vx_q;  flag_d = vy_q >= vx_q; end
              ALU_SHL: begin v_wdata = vx_q << 1;    flag_d = vx_q[7]; end
              default: begin v_we = 1'b0;            state_d = ST_DONE; end
            endcase
          end
          OPC_LDIX: i_d = op_nnn;
          OPC_JPV0: pc_d = op_nnn + {4'd0, v_rd};
          OPC_RND: begin
            v_we = 1'b1;  v_waddr = op_x;  v_wdata = rnd_q & op_nn;
          end
          OPC_DRW: begin
            chg_d = 1'b1;
            if (op_n == 4'd0) begin
              flag_d  = 1'b0;
              state_d = ST_FLAG;
            end else begin
              state_d = ST_DRAW_RD;
            end
          end
          OPC_KEY: begin
            if (op_nn == KEY_SKP && keys_q[vx_q[3:0]]) pc_d = pc_q + 12'd2;
            if (op_nn == KEY_SKNP && !keys_q[vx_q[3:0]]) pc_d = pc_q + 12'd2;
          end
          OPC_MISC: begin
            case (op_nn)
              FN_GET_DT: begin
                v_we = 1'b1;  v_waddr = op_x;  v_wdata = dt_q;
              end
              FN_WAIT_K: begin
                if (key_any) begin
                  v_we = 1'b1;  v_waddr = op_x;  v_wdata = {4'd0, key_idx};
                end else begin
                  pc_d = pc_q - 12'd2;  wait_d = 1'b1;
                end
              end
              FN_SET_DT: dt_d = vx_q;
              FN_SET_ST: st_d = vx_q;
              FN_ADD_I:  i_d = i_q + {4'd0, vx_q};
              FN_FONT:   i_d = FONT_BASE + {6'd0, vx_q[3:0], 2'd0} + {8'd0, vx_q[3:0]};
              FN_BCD:    state_d = ST_BCD;
              FN_STORE:  state_d = ST_STORE_RD;
              FN_LOAD:   state_d = ST_LOAD_RD;
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      ST_RET: begin
        pc_d = stk_rdata;  state_d = ST_DONE;
      end
      ST_FLAG: begin
        v_we = 1'b1;  v_waddr = 4'hF;  v_wdata = {7'd0, flag_q};
        state_d = ST_DONE;
      end
      ST_DRAW_RD: begin
        pm_raddr = i_q + {8'd0, cnt_q};
        fb_raddr = draw_y;
        state_d  = ST_DRAW_WR;
      end
      ST_DRAW_WR: begin
        fb_we    = 1'b1;
        fb_waddr = draw_y;
        fb_wdata = fb_old ^ spr_rot;
        fb_vld_d[draw_y] = 1'b1;
        hit_d    = hit_q | (|(fb_old & spr_rot));
        cnt_d    = cnt_q + 4'd1;
        if (cnt_q == op_n - 4'd1) begin
          flag_d  = hit_q | (|(fb_old & spr_rot));
          state_d = ST_FLAG;
        end else begin
          state_d = ST_DRAW_RD;
        end
      end
      ST_BCD: begin
        pm_we    = 1'b1;
        pm_waddr = i_q + {8'd0, cnt_q};
        cnt_d    = cnt_q + 4'd1;
        case (cnt_q[1:0])
          2'd0:    pm_wdata = {6'd0, bcd_h};
          2'd1:    pm_wdata = {4'd0, bcd_t};
          default: pm_wdata = {4'd0, bcd_o};
        endcase
        if (cnt_q == 4'd2) state_d = ST_DONE;
      end
      ST_STORE_RD: begin
        v_raddr = cnt_q;  state_d = ST_STORE_WR;
      end
      ST_STORE_WR: begin
        v_raddr  = cnt_q;
        pm_we    = 1'b1;
        pm_waddr = i_q + {8'd0, cnt_q};
        pm_wdata = v_rd;
        cnt_d    = cnt_q + 4'd1;
        state_d  = (cnt_q == op_x) ? ST_DONE : ST_STORE_RD;
      end
      ST_LOAD_RD: begin
        pm_raddr = i_q + {8'd0, cnt_q};  state_d = ST_LOAD_WR;
      end
      ST_LOAD_WR: begin
        v_we = 1'b1;  v_waddr = cnt_q;  v_wdata = pm_rdata;
        cnt_d   = cnt_q + 4'd1;
        state_d = (cnt_q == op_x) ? ST_DONE : ST_LOAD_RD;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (v_we) v_vld_d[v_waddr] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;  clr_q <= 12'd0;  pc_q <= PC_START;  i_q <= 12'd0;
      sp_q <= '0;  dt_q <= 8'd0;  st_q <= 8'd0;  fb_vld_q <= 32'd0;
      v_vld_q <= 16'd0;  cnt_q <= 4'd0;  hit_q <= 1'b0;  flag_q <= 1'b0;
      out_valid_q <= 1'b0;  v_raddr_q <= 4'd0;
    end else begin
      state_q <= state_d;  clr_q <= clr_d;  pc_q <= pc_d;  i_q <= i_d;
      sp_q <= sp_d;  dt_q <= dt_d;  st_q <= st_d;  fb_vld_q <= fb_vld_d;
      v_vld_q <= v_vld_d;  cnt_q <= cnt_d;  hit_q <= hit_d;  flag_q <= flag_d;
      out_valid_q <= out_valid_d;  v_raddr_q <= v_raddr;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;  vx_q <= vx_d;  vy_q <= vy_d;  cmd_q <= cmd_d;  addr_q <= addr_d;
    wd_q <= wd_d;  rnd_q <= rnd_d;  rd_q <= rd_d;  keys_q <= keys_d;
    row_q <= row_d;  drow_q <= drow_d;  chg_q <= chg_d;  wait_q <= wait_d;
    fault_q <= fault_d;
    if (out_load) begin
      read_data_o       <= rd_q;
      display_row_o     <= drow_q;
      program_counter_o <= pc_q;
      display_changed_o <= chg_q;
      sound_on_o        <= st_q != 8'd0;
      waiting_for_key_o <= wait_q;
      stack_fault_o     <= fault_q;
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

FILE: rtl/core/c8_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c8_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module c8_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

FILE: tb/chip8_instruction_core_checker.sv
// ----------------------------------------------------------------------------
// chip8_instruction_core_checker
// Watches both channels of the CHIP-8 core. Each accepted input transaction
// runs through a behavioral model of the core; the predicted result is
// queued. Each output transaction is compared field by field with the oldest
// queued result.
// ----------------------------------------------------------------------------
module chip8_instruction_core_checker #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  command_i,
  input  logic [11:0] address_i,
  input  logic [7:0]  write_data_i,
  input  logic [15:0] keys_down_i,
  input  logic [7:0]  random_byte_i,
  input  logic [4:0]  row_select_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  read_data_i,
  input  logic [63:0] display_row_i,
  input  logic [11:0] program_counter_i,
  input  logic        display_changed_i,
  input  logic        sound_on_i,
  input  logic        waiting_for_key_i,
  input  logic        stack_fault_i,
  output int          fail_count_o,
  output int          pending_o
);
  import c8_pkg::*;

  typedef struct packed {
    logic [7:0]  rdata;
    logic [63:0] row;
    logic [11:0] pc;
    logic        changed;
    logic        sound;
    logic        waiting;
    logic        fault;
  } c8_result_t;

  logic [7:0]  mem [4096];
  logic [7:0]  v [16];
  logic [11:0] idx;
  logic [11:0] pc;
  logic [11:0] stk [STACK_DEPTH];
  int unsigned sp;
  logic [7:0]  dt, st;
  logic [63:0] fb [32];
  c8_result_t  result_q [$];

  initial begin
    for (int k = 0; k < 4096; k++) mem[k] = 8'h00;
    for (int k = 0; k < FontBytes; k++) mem[FONT_BASE + k] = FONT[k];
    for (int k = 0; k < 16; k++) v[k] = 8'h00;
    for (int k = 0; k < 32; k++) fb[k] = '0;
    for (int k = 0; k < STACK_DEPTH; k++) stk[k] = '0;
    idx = '0;
    pc = PC_START;
    sp = 0;
    dt = '0;
    st = '0;
    fail_count_o = 0;
  end

  assign pending_o = result_q.size();

  task automatic sprite_draw(input logic [7:0] xp, input logic [7:0] yp,
                             input logic [3:0] h);
    logic [7:0]  bits;
    logic        hit;
    int unsigned yy, xx;
    hit = 1'b0;
    for (int r = 0; r < h; r++) begin
      bits = mem[12'(idx + r)];
      yy = (yp + r) % 32;
      for (int c = 0; c < 8; c++) begin
        if (bits[7-c]) begin
          xx = (xp + c) % 64;
          if (fb[yy][xx]) hit = 1'b1;
          fb[yy][xx] = ~fb[yy][xx];
        end
      end
    end
    v[15] = {7'd0, hit};
  endtask

  task automatic run_instruction(input logic [15:0] keys, input logic [7:0] rnd,
                                 inout c8_result_t res);
    logic [15:0] op;
    logic [3:0]  x, y, n;
    logic [7:0]  nn, vx, vy;
    logic        found;
    op = {mem[pc], mem[12'(pc + 1)]};
    x  = op[11:8];
    y  = op[7:4];
    n  = op[3:0];
    nn = op[7:0];
    vx = v[x];
    vy = v[y];
    found = 1'b0;
    pc = pc + 12'd2;
    case (opc_e'(op[15:12]))
      OPC_SYS: begin
        if (op == OP_CLS) begin
          for (int k = 0; k < 32; k++) fb[k] = '0;
          res.changed = 1'b1;
        end else if (op == OP_RET) begin
          if (sp == 0) res.fault = 1'b1;
          else begin
            sp--;
            pc = stk[sp];
          end
        end
      end
      OPC_JP: pc = op[11:0];
      OPC_CALL: begin
        if (sp >= STACK_DEPTH) res.fault = 1'b1;
        else begin
          stk[sp] = pc;
          sp++;
          pc = op[11:0];
        end
      end
      OPC_SEI:  if (vx == nn) pc = pc + 12'd2;
      OPC_SNEI: if (vx != nn) pc = pc + 12'd2;
      OPC_SER:  if (vx == vy) pc = pc + 12'd2;
      OPC_LDI:  v[x] = nn;
      OPC_ADDI: v[x] = vx + nn;
      OPC_ALU: begin
        case (n)
          ALU_MOV: v[x] = vy;
          ALU_OR:  v[x] = vx | vy;
          ALU_AND: v[x] = vx & vy;
          ALU_XOR: v[x] = vx ^ vy;
          ALU_ADD: begin v[x] = vx + vy; v[15] = ({1'b0, vx} + vy > 9'd255); end
          ALU_SUB: begin v[x] = vx - vy; v[15] = (vx >= vy); end
          ALU_SHR: begin v[x] = vx >> 1; v[15] = vx[0]; end
          ALU_SBN: begin v[x] = vy - vx; v[15] = (vy >= vx); end
          ALU_SHL: begin v[x] = vx << 1; v[15] = vx[7]; end
          default: ;
        endcase
      end
      OPC_SNER: if (vx != vy) pc = pc + 12'd2;
      OPC_LDIX: idx = op[11:0];
      OPC_JPV0: pc = op[11:0] + v[0];
      OPC_RND:  v[x] = rnd & nn;
      OPC_DRW: begin
        sprite_draw(vx, vy, n);
        res.changed = 1'b1;
      end
      OPC_KEY: begin
        if (nn == KEY_SKP && keys[vx[3:0]]) pc = pc + 12'd2;
        else if (nn == KEY_SKNP && !keys[vx[3:0]]) pc = pc + 12'd2;
      end
      OPC_MISC: begin
        case (nn)
          FN_GET_DT: v[x] = dt;
          FN_WAIT_K: begin
            for (int k = 0; k < 16; k++) begin
              if (!found && keys[k]) begin
                v[x] = 8'(k);
                found = 1'b1;
              end
            end
            if (!found) begin
              pc = pc - 12'd2;
              res.waiting = 1'b1;
            end
          end
          FN_SET_DT: dt = vx;
          FN_SET_ST: st = vx;
          FN_ADD_I:  idx = idx + vx;
          FN_FONT:   idx = FONT_BASE + 12'(vx[3:0]) * 12'd5;
          FN_BCD: begin
            mem[idx] = vx / 100;
            mem[12'(idx + 1)] = (vx / 10) % 10;
            mem[12'(idx + 2)] = vx % 10;
          end
          FN_STORE: for (int k = 0; k <= x; k++) mem[12'(idx + k)] = v[k];
          FN_LOAD:  for (int k = 0; k <= x; k++) v[k] = mem[12'(idx + k)];
          default: ;
        endcase
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    c8_result_t res;
    c8_result_t exp_res;
    if (rst_ni && in_valid_i && !in_stall_i) begin
      res = '0;
      case (command_i)
        CMD_WRITE: mem[address_i] = write_data_i;
        CMD_EXEC:  run_instruction(keys_down_i, random_byte_i, res);
        CMD_TICK: begin
          if (dt != 0) dt--;
          if (st != 0) st--;
        end
        CMD_ROW:  res.row = fb[row_select_i];
        CMD_READ: res.rdata = mem[address_i];
        default: ;
      endcase
      res.pc = pc;
      res.sound = (st != 0);
      result_q.push_back(res);
    end
    if (rst_ni && out_valid_i && !out_stall_i) begin
      if (result_q.size() == 0) begin
        $error("result with no transaction outstanding");
        fail_count_o++;
      end else begin
        exp_res = result_q.pop_front();
        if (read_data_i !== exp_res.rdata) begin
          $error("read_data exp %h got %h", exp_res.rdata, read_data_i);
          fail_count_o++;
        end
        if (display_row_i !== exp_res.row) begin
          $error("display_row exp %h got %h", exp_res.row, display_row_i);
          fail_count_o++;
        end
        if (program_counter_i !== exp_res.pc) begin
          $error("program_counter exp %h got %h", exp_res.pc, program_counter_i);
          fail_count_o++;
        end
        if (display_changed_i !== exp_res.changed) begin
          $error("display_changed exp %b got %b", exp_res.changed, display_changed_i);
          fail_count_o++;
        end
        if (sound_on_i !== exp_res.sound) begin
          $error("sound_on exp %b got %b", exp_res.sound, sound_on_i);
          fail_count_o++;
        end
        if (waiting_for_key_i !== exp_res.waiting) begin
          $error("waiting_for_key exp %b got %b", exp_res.waiting, waiting_for_key_i);
          fail_count_o++;
        end
        if (stack_fault_i !== exp_res.fault) begin
          $error("stack_fault exp %b got %b", exp_res.fault, stack_fault_i);
          fail_count_o++;
        end
      end
    end
  end

endmodule

FILE: tb/chip8_instruction_core_top_tb.sv
// ----------------------------------------------------------------------------
// chip8_instruction_core_top_tb
// Drives the CHIP-8 core with memory writes of small random programs,
// execution runs over them, timer ticks, row reads and memory reads, plus
// directed opcode cases, under random idling on both channels. The checker
// beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module chip8_instruction_core_top_tb;
  import c8_pkg::*;

  localparam int WatchdogLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  command = '0;
  logic [11:0] address = '0;
  logic [7:0]  write_data = '0;
  logic [15:0] keys_down = '0;
  logic [7:0]  random_byte = '0;
  logic [4:0]  row_select = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [7:0]  read_data;
  logic [63:0] display_row;
  logic [11:0] program_counter;
  logic        display_changed, sound_on, waiting_for_key, stack_fault;
  int          fail_count, pending;
  int          idle_pct = 34;
  int          quiet_cycles = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  chip8_instruction_core_top i_dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .command_i(command), .address_i(address), .write_data_i(write_data),
    .keys_down_i(keys_down), .random_byte_i(random_byte),
    .row_select_i(row_select),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .read_data_o(read_data), .display_row_o(display_row),
    .program_counter_o(program_counter), .display_changed_o(display_changed),
    .sound_on_o(sound_on), .waiting_for_key_o(waiting_for_key),
    .stack_fault_o(stack_fault)
  );

  chip8_instruction_core_checker i_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .command_i(command), .address_i(address), .write_data_i(write_data),
    .keys_down_i(keys_down), .random_byte_i(random_byte),
    .row_select_i(row_select),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .read_data_i(read_data), .display_row_i(display_row),
    .program_counter_i(program_counter), .display_changed_i(display_changed),
    .sound_on_i(sound_on), .waiting_for_key_i(waiting_for_key),
    .stack_fault_i(stack_fault),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else if (rst_ni) quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send(input cmd_e cmd, input logic [11:0] addr, input logic [7:0] wd,
                      input logic [15:0] keys, input logic [7:0] rnd,
                      input logic [4:0] rsel);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    address     <= addr;
    write_data  <= wd;
    keys_down   <= keys;
    random_byte <= rnd;
    row_select  <= rsel;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic put_op(input logic [11:0] addr, input logic [15:0] op);
    send(CMD_WRITE, addr, op[15:8], 16'($urandom), 8'($urandom), 5'($urandom));
    send(CMD_WRITE, addr + 12'd1, op[7:0], 16'($urandom), 8'($urandom), 5'($urandom));
  endtask

  task automatic exec_op(input logic [15:0] keys);
    send(CMD_EXEC, 12'($urandom), 8'($urandom), keys, 8'($urandom), 5'($urandom));
  endtask

  function automatic logic [15:0] random_op();
    logic [15:0] op;
    op = 16'($urandom);
    case ($urandom_range(9))
      0: op[15:12] = 4'h8;
      1: op = {4'hF, op[11:8], 8'($urandom_range(1) ? FN_STORE : FN_LOAD)};
      2: begin
        op[15:12] = 4'hD;
        op[3:0] = 4'($urandom_range(4));
      end
      3: op = 16'($urandom_range(1) ? OP_RET : OP_CLS);
      4: op = {4'hF, op[11:8], 8'($urandom_range(1) ? FN_BCD : FN_WAIT_K)};
      5: op = {4'hE, op[11:8], 8'($urandom_range(1) ? KEY_SKP : KEY_SKNP)};
      6: op = {4'hF, op[11:8], 8'($urandom_range(1) ? FN_SET_ST : FN_FONT)};
      default: ;
    endcase
    return op;
  endfunction

  function automatic logic [15:0] random_keys();
    return ($urandom_range(3) == 0) ? 16'h0000 : 16'($urandom);
  endfunction

  logic [11:0] base;
  logic [15:0] dir_ops [21] = '{
    16'h00EE, 16'h60FF, 16'h61FF, 16'h8014, 16'h8015, 16'h8017, 16'h8F16,
    16'h8F0E, 16'hA000, 16'hF033, 16'hD01F, 16'hF029, 16'hDFFF, 16'h00E0,
    16'hF00A, 16'hFF55, 16'hFF65, 16'hF018, 16'hF115, 16'hF107, 16'h5123
  };

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int k = 0; k < 21; k++) put_op(12'(PC_START + 2 * k), dir_ops[k]);
    for (int k = 0; k < 21; k++) exec_op(k == 14 ? 16'h0000 : 16'hFFFF);
    exec_op(16'h8000);
    send(CMD_TICK, '0, '0, '0, '0, '0);
    for (int r = 0; r < 32; r += 31) send(CMD_ROW, '0, '0, '0, '0, 5'(r));
    send(CMD_READ, 12'hFFF, '0, '0, '0, '0);
    for (int k = 0; k < 17; k++) put_op(12'(16'h300 + 2 * k), 16'h2300 + 16'(2 * k + 2));
    put_op(12'h222, 16'h1300);
    exec_op(16'h0);
    for (int k = 0; k < 18; k++) exec_op(16'h0);
    for (int k = 0; k < 18; k++) begin
      put_op(12'h320, 16'h00EE);
      send(CMD_WRITE, 12'hFFF, 8'h13, '0, '0, '0);
    end
    for (int seq = 0; seq < 39; seq++) begin
      idle_pct = (seq >= 20 && seq < 26) ? 0 : 34;
      base = 12'($urandom) & 12'hFFE;
      if (seq % 10 == 9) base = 12'hFFE;
      put_op(base, 16'h1000 | 16'(base + 12'd4));
      for (int k = 2; k < 16; k += 2) put_op(12'(base + k), random_op());
      put_op(12'(base + 16), 16'h1000 | 16'(base + 12'd4));
      exec_op(16'h0);
      for (int k = 0; k < 10; k++) begin
        case ($urandom_range(9))
          0: send(CMD_TICK, 12'($urandom), 8'($urandom), '0, '0, '0);
          1: send(CMD_ROW, 12'($urandom), '0, '0, '0, 5'($urandom));
          2: send(CMD_READ, 12'($urandom), '0, '0, '0, '0);
          3: send(cmd_e'(3'($urandom_range(5, 7))), 12'($urandom), 8'($urandom),
                  16'($urandom), 8'($urandom), 5'($urandom));
          default: exec_op(random_keys());
        endcase
      end
    end
    in_valid <= 1'b0;
    idle_pct = 34;
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
